// ===== rtl/core/gae_pkg.sv =====
package gae_pkg;

    // Default configuration of the block.
    localparam int DEF_MAX_LOG_DEGREE = 12;
    localparam int DEF_COEFF_WIDTH    = 61;

    // Configuration channel.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int LOG_REG_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_DEGREE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GALOIS_ELEMENT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS        = 2'd3;

    // Request types.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Domain modes.
    localparam logic MODE_COEFF = 1'b0;
    localparam logic MODE_NTT   = 1'b1;

    // Reset values of the registers.
    localparam logic [LOG_REG_W-1:0] LOG_DEGREE_RESET = 4'd12;
    localparam int                   MIN_LOG_DEGREE   = 2;

endpackage

// ===== rtl/core/galois_automorphism_engine.sv =====
// Galois automorphism engine: applies X -> X^g to one polynomial held in an
// internal coefficient store of 2^MAX_LOG_DEGREE entries.
// Request channel: a transaction is taken at a rising edge with i_start high
// and o_busy low. o_busy is always low, so one request may be issued in every
// cycle. A write request (i_req_type = 0) stores i_coeff_value at the
// permuted (coefficient mode, with negation mod q) or the plain (NTT mode)
// position and gives no result. A read request returns one result.
// Result channel: o_strobe is high for one cycle with o_read_value; the
// receiver cannot hold results off and the block never waits on it.
// Pipeline: throughput is one request per cycle; the pipeline has four
// register stages (capture and operand, multiply, index and negate, store
// access), a read's result shows after the last of them, and reads and
// writes are kept in order, so a read sees every earlier write.
// Configuration channel: i_cfg_valid/o_cfg_ready with a register index and
// data; o_cfg_ready is always high. The user must write registers only while
// no request is in flight; the block itself does not enforce it.
// Reset (synchronous, active low) empties the pipeline and restores the
// registers; the store contents are undefined until written.
module galois_automorphism_engine #(
    parameter int MAX_LOG_DEGREE = gae_pkg::DEF_MAX_LOG_DEGREE,
    parameter int COEFF_WIDTH    = gae_pkg::DEF_COEFF_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic                            i_req_type,
    input  logic [MAX_LOG_DEGREE-1:0]       i_position,
    input  logic [COEFF_WIDTH-1:0]          i_coeff_value,
    output logic                            o_strobe,
    output logic [COEFF_WIDTH-1:0]          o_read_value,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gae_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gae_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gae_pkg::*;

    localparam int PosW  = MAX_LOG_DEGREE;
    localparam int GW    = MAX_LOG_DEGREE + 1;
    localparam int LogW  = $clog2(MAX_LOG_DEGREE + 1);
    localparam int Depth = 1 << MAX_LOG_DEGREE;

    function automatic logic [LogW-1:0] clamp_log(input logic [LOG_REG_W-1:0] v);
        logic [LogW-1:0] res;
        if (int'(v) < MIN_LOG_DEGREE) begin
            res = LogW'(MIN_LOG_DEGREE);
        end else if (int'(v) > MAX_LOG_DEGREE) begin
            res = LogW'(MAX_LOG_DEGREE);
        end else begin
            res = LogW'(v);
        end
        return res;
    endfunction

    function automatic logic [PosW-1:0] mask_of(input logic [LogW-1:0] lg);
        return PosW'((1 << lg) - 1);
    endfunction

    // Configuration registers, with the derived degree values held alongside.
    logic                   r_mode;
    logic [LogW-1:0]        r_eff_log;
    logic [PosW-1:0]        r_nmask;
    logic [LogW-1:0]        r_rev_shift;
    logic [GW-1:0]          r_galois;
    logic [COEFF_WIDTH-1:0] r_modulus;
    logic [LogW-1:0]        n_eff_log;

    logic accept;

    // Stage A: captured request and multiplier operand.
    logic                   r_a_valid;
    logic                   r_a_read;
    logic                   r_a_mode;
    logic [PosW-1:0]        r_a_pos;
    logic [GW-1:0]          r_a_oper;
    logic [COEFF_WIDTH-1:0] r_a_value;
    logic [PosW-1:0]        n_a_pos;
    logic [GW-1:0]          n_a_oper;
    logic [GW-1:0]          a_nplus;
    logic [GW-1:0]          a_rev_full;

    // Stage B: product.
    logic                   r_b_valid;
    logic                   r_b_read;
    logic                   r_b_mode;
    logic [PosW-1:0]        r_b_pos;
    logic [GW-1:0]          r_b_prod;
    logic [COEFF_WIDTH-1:0] r_b_value;
    logic [2*GW-1:0]        b_prod_full;

    // Stage C: store index and data to write.
    logic                   r_c_valid;
    logic                   r_c_read;
    logic [PosW-1:0]        r_c_index;
    logic [COEFF_WIDTH-1:0] r_c_wdata;
    logic [PosW-1:0]        n_c_index;
    logic [COEFF_WIDTH-1:0] n_c_wdata;
    logic [PosW-1:0]        c_raw;
    logic [PosW-1:0]        c_src_full;
    logic [PosW-1:0]        c_src;
    logic [PosW-1:0]        c_perm;
    logic                   c_neg;

    // Stage D: store access and result.
    logic [COEFF_WIDTH-1:0] r_store [Depth];
    logic [COEFF_WIDTH-1:0] r_rd_data;
    logic                   r_out_valid;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    assign n_eff_log = clamp_log(i_cfg_data[LOG_REG_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_COEFF;
            r_eff_log   <= clamp_log(LOG_DEGREE_RESET);
            r_nmask     <= mask_of(clamp_log(LOG_DEGREE_RESET));
            r_rev_shift <= LogW'(MAX_LOG_DEGREE) - clamp_log(LOG_DEGREE_RESET);
            r_galois    <= GW'(1);
            r_modulus   <= COEFF_WIDTH'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DOMAIN_MODE: begin
                    r_mode <= i_cfg_data[0];
                end
                CFG_LOG_DEGREE: begin
                    r_eff_log   <= n_eff_log;
                    r_nmask     <= mask_of(n_eff_log);
                    r_rev_shift <= LogW'(MAX_LOG_DEGREE) - n_eff_log;
                end
                CFG_GALOIS_ELEMENT: begin
                    r_galois <= i_cfg_data[GW-1:0];
                end
                CFG_MODULUS: begin
                    r_modulus <= i_cfg_data[COEFF_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // NTT-mode operand: bitrev(N + pos, lg + 1), taken as a full-width
    // reversal followed by a right shift that drops the unused low bits.
    always_comb begin
        n_a_pos = i_position & r_nmask;
        a_nplus = {1'b0, n_a_pos} | (GW'(1) << r_eff_log);
        for (int k = 0; k < GW; k++) begin
            a_rev_full[GW-1-k] = a_nplus[k];
        end
        if (r_mode == MODE_NTT) begin
            n_a_oper = a_rev_full >> r_rev_shift;
        end else begin
            n_a_oper = {1'b0, n_a_pos};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= accept;
        end
        r_a_read  <= i_req_type;
        r_a_mode  <= r_mode;
        r_a_pos   <= n_a_pos;
        r_a_oper  <= n_a_oper;
        r_a_value <= i_coeff_value;
    end

    // Only the low lg + 1 bits of the product matter in either mode.
    assign b_prod_full = r_a_oper * r_galois;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
        r_b_read  <= r_a_read;
        r_b_mode  <= r_a_mode;
        r_b_pos   <= r_a_pos;
        r_b_prod  <= b_prod_full[GW-1:0];
        r_b_value <= r_a_value;
    end

    always_comb begin
        c_perm = r_b_prod[PosW-1:0] & r_nmask;
        c_neg  = r_b_prod[r_eff_log];
        c_raw  = r_b_prod[GW-1:1] & r_nmask;
        for (int k = 0; k < PosW; k++) begin
            c_src_full[PosW-1-k] = c_raw[k];
        end
        c_src = c_src_full >> r_rev_shift;

        if (r_b_read == REQ_READ) begin
            n_c_index = (r_b_mode == MODE_NTT) ? c_src : r_b_pos;
        end else begin
            n_c_index = (r_b_mode == MODE_NTT) ? r_b_pos : c_perm;
        end

        // In coefficient mode a wrap past X^N flips the sign; zero stays zero.
        if (r_b_mode == MODE_COEFF && c_neg && r_b_value != '0) begin
            n_c_wdata = r_modulus - r_b_value;
        end else begin
            n_c_wdata = r_b_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= r_b_valid;
        end
        r_c_read  <= r_b_read;
        r_c_index <= n_c_index;
        r_c_wdata <= n_c_wdata;
    end

    // Single-port store: each transaction either writes or reads one entry.
    always_ff @(posedge i_clk) begin
        if (r_c_valid && r_c_read == REQ_WRITE) begin
            r_store[r_c_index] <= r_c_wdata;
        end
        if (r_c_valid && r_c_read == REQ_READ) begin
            r_rd_data <= r_store[r_c_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_c_valid && (r_c_read == REQ_READ);
        end
    end

    assign o_strobe     = r_out_valid;
    assign o_read_value = r_rd_data;

    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && i_req_type == REQ_READ && i_rst_n, 4))
        else $error("result strobe without a matching read request");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid |-> ((r_c_index & ~r_nmask) == '0))
        else $error("store index beyond the polynomial degree");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_valid && r_c_read == REQ_WRITE) |=> !o_strobe)
        else $error("write request produced a result");

endmodule
